FILE: hdl/cst_pkg.sv
// Shared types and constants for the C subset tokenizer.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package cst_pkg;

	// Field widths
	localparam int KIND_BITS = 5;
	localparam int LEN_BITS  = 9;   // lexeme counter, saturates at 256
	localparam int TLEN_BITS = 8;   // reported length
	localparam int TLINE_BITS = 20; // reported line
	localparam int ERR_BITS  = 2;

	// Result queue geometry
	localparam int QDEPTH   = 4;
	localparam int QPTR_BITS = 2;
	localparam int QCNT_BITS = 3;

	// Token kinds
	localparam logic [KIND_BITS-1:0] K_IDENT  = 5'd0;
	localparam logic [KIND_BITS-1:0] K_NUM    = 5'd1;
	localparam logic [KIND_BITS-1:0] K_STR    = 5'd2;
	localparam logic [KIND_BITS-1:0] K_PLUS   = 5'd3;
	localparam logic [KIND_BITS-1:0] K_MINUS  = 5'd4;
	localparam logic [KIND_BITS-1:0] K_STAR   = 5'd5;
	localparam logic [KIND_BITS-1:0] K_DIV    = 5'd6;
	localparam logic [KIND_BITS-1:0] K_MOD    = 5'd7;
	localparam logic [KIND_BITS-1:0] K_ASSIGN = 5'd8;
	localparam logic [KIND_BITS-1:0] K_EQ     = 5'd9;
	localparam logic [KIND_BITS-1:0] K_NEQ    = 5'd10;
	localparam logic [KIND_BITS-1:0] K_LT     = 5'd11;
	localparam logic [KIND_BITS-1:0] K_LEQ    = 5'd12;
	localparam logic [KIND_BITS-1:0] K_GT     = 5'd13;
	localparam logic [KIND_BITS-1:0] K_GEQ    = 5'd14;
	localparam logic [KIND_BITS-1:0] K_SEMI   = 5'd15;
	localparam logic [KIND_BITS-1:0] K_LPA    = 5'd16;
	localparam logic [KIND_BITS-1:0] K_RPA    = 5'd17;
	localparam logic [KIND_BITS-1:0] K_LSB    = 5'd18;
	localparam logic [KIND_BITS-1:0] K_RSB    = 5'd19;
	localparam logic [KIND_BITS-1:0] K_BEGIN  = 5'd20;
	localparam logic [KIND_BITS-1:0] K_END    = 5'd21;
	localparam logic [KIND_BITS-1:0] K_COMMA  = 5'd22;
	localparam logic [KIND_BITS-1:0] K_EOF    = 5'd23;
	localparam logic [KIND_BITS-1:0] K_ERR    = 5'd24;

	// Error codes
	localparam logic [ERR_BITS-1:0] E_NONE    = 2'd0;
	localparam logic [ERR_BITS-1:0] E_BANG    = 2'd1;
	localparam logic [ERR_BITS-1:0] E_UNKNOWN = 2'd2;
	localparam logic [ERR_BITS-1:0] E_UNTERM  = 2'd3;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_LPA   = 8'h28;
	localparam logic [7:0] CH_RPA   = 8'h29;
	localparam logic [7:0] CH_LSB   = 8'h5b;
	localparam logic [7:0] CH_RSB   = 8'h5d;
	localparam logic [7:0] CH_LCB   = 8'h7b;
	localparam logic [7:0] CH_RCB   = 8'h7d;
	localparam logic [7:0] CH_COMMA = 8'h2c;

	// One result item
	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [TLEN_BITS-1:0]  length;
		logic                  saturated;
		logic [TLINE_BITS-1:0] line;
		logic [ERR_BITS-1:0]   err;
		logic                  last;
	} token_t;

	// Results produced by one input transfer, in order
	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} emit_t;

endpackage

FILE: hdl/cst_if.sv
// Valid/ready channel interfaces for source bytes and tokens.
// Depends on cst_pkg for field widths.
`timescale 1ns / 1ps

interface cst_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_end;

	modport source (output valid, output in_byte, output is_end, input ready);
	modport sink (input valid, input in_byte, input is_end, output ready);
endinterface

interface cst_token_if;
	logic                           valid;
	logic                           ready;
	logic [cst_pkg::KIND_BITS-1:0]  token_kind;
	logic [cst_pkg::TLEN_BITS-1:0]  token_length;
	logic                           length_saturated;
	logic [cst_pkg::TLINE_BITS-1:0] token_line;
	logic [cst_pkg::ERR_BITS-1:0]   error_code;
	logic                           last_of_run;

	modport source (output valid, output token_kind, output token_length,
		output length_saturated, output token_line, output error_code,
		output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_length,
		input length_saturated, input token_line, input error_code,
		input last_of_run, output ready);
endinterface

FILE: hdl/c_subset_tokenizer_unit.sv
// Output: a token completed by a byte transfer is written into the token queue and leaves from its head.
// Throughput: one byte per cycle while the four-entry token queue has room for two results;
// a byte completing two tokens fills two queue slots and the queue drains one per transfer.
// Reset: arst_n clears the lexer to its start state, line one, and empties the token queue.
// Top level: joins cst_lexer and cst_token_fifo; depends on cst_pkg and cst_if.
`timescale 1ns / 1ps

module c_subset_tokenizer_unit #(
	parameter int LINE_BITS = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	cst_byte_if.sink          chars,
	cst_token_if.source       tokens
);

	cst_pkg::emit_t  emit;
	cst_pkg::token_t head;
	logic            has_room;
	logic            step;

	// Accept a byte whenever two result slots are free
	assign chars.ready = has_room;
	assign step        = chars.valid && has_room;

	cst_lexer #(
		.LINE_BITS(LINE_BITS)
	) u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_byte (chars.in_byte),
		.is_end  (chars.is_end),
		.emit    (emit)
	);

	cst_token_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.has_room  (has_room),
		.out_valid (tokens.valid),
		.out_ready (tokens.ready),
		.out_tok   (head)
	);

	// Drive the token channel from the queue head
	assign tokens.token_kind       = head.kind;
	assign tokens.token_length     = head.length;
	assign tokens.length_saturated = head.saturated;
	assign tokens.token_line       = head.line;
	assign tokens.error_code       = head.err;
	assign tokens.last_of_run      = head.last;

endmodule

FILE: hdl/cst_lexer.sv
// Lexer state registers and the per-byte transition logic.
// Produces up to two tokens per transfer; depends on cst_pkg.
`timescale 1ns / 1ps

module cst_lexer #(
	parameter int LINE_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           in_byte,
	input  logic                 is_end,
	output cst_pkg::emit_t       emit
);

	localparam logic [3:0] S_START      = 4'd0;
	localparam logic [3:0] S_SLASH      = 4'd1;
	localparam logic [3:0] S_LINECOM    = 4'd2;
	localparam logic [3:0] S_BLOCK      = 4'd3;
	localparam logic [3:0] S_BLOCK_STAR = 4'd4;
	localparam logic [3:0] S_IDENT      = 4'd5;
	localparam logic [3:0] S_NUM_INT    = 4'd6;
	localparam logic [3:0] S_NUM_FRAC   = 4'd7;
	localparam logic [3:0] S_STRING     = 4'd8;
	localparam logic [3:0] S_EQ         = 4'd9;
	localparam logic [3:0] S_BANG       = 4'd10;
	localparam logic [3:0] S_LT         = 4'd11;
	localparam logic [3:0] S_GT         = 4'd12;

	localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [cst_pkg::LEN_BITS-1:0] LEN_MAX =
		cst_pkg::LEN_BITS'(256);

	// Outcome of a byte seen in the start state
	typedef struct packed {
		logic [3:0]                   state;
		logic [cst_pkg::LEN_BITS-1:0] len;
		logic                         set_quote;
		logic                         bump;
		logic                         tok_v;
		logic [cst_pkg::KIND_BITS-1:0] kind;
		logic [cst_pkg::ERR_BITS-1:0]  err;
	} start_t;

	logic [3:0]                   state_q;
	logic [LINE_BITS-1:0]         line_q;
	logic [cst_pkg::LEN_BITS-1:0] len_q;
	logic [LINE_BITS-1:0]         sline_q;
	logic [7:0]                   quote_q;

	logic [3:0]                   nxt_state;
	logic [LINE_BITS-1:0]         nxt_line;
	logic [cst_pkg::LEN_BITS-1:0] nxt_len;
	logic [LINE_BITS-1:0]         nxt_sline;
	logic [7:0]                   nxt_quote;
	logic                         bump;
	logic                         use_start;
	logic                         pre_v;
	logic                         sec_v;
	cst_pkg::token_t              pre_tok;
	cst_pkg::token_t              sec_tok;
	start_t                       sb;
	logic [cst_pkg::LEN_BITS-1:0] len_inc;
	logic                         is_alpha;
	logic                         is_digit;

	function automatic start_t start_byte(input logic [7:0] c);
		start_t r;
		r.state     = S_START;
		r.len       = cst_pkg::LEN_BITS'(1);
		r.set_quote = 1'b0;
		r.bump      = 1'b0;
		r.tok_v     = 1'b1;
		r.kind      = cst_pkg::K_ERR;
		r.err       = cst_pkg::E_NONE;
		case (c) inside
			cst_pkg::CH_SPACE, cst_pkg::CH_TAB, cst_pkg::CH_CR: r.tok_v = 1'b0;
			cst_pkg::CH_NL: begin
				r.tok_v = 1'b0;
				r.bump  = 1'b1;
			end
			cst_pkg::CH_SLASH: begin
				r.tok_v = 1'b0;
				r.state = S_SLASH;
			end
			[8'h61:8'h7a], [8'h41:8'h5a], cst_pkg::CH_UNDER: begin
				r.tok_v = 1'b0;
				r.state = S_IDENT;
			end
			[8'h30:8'h39]: begin
				r.tok_v = 1'b0;
				r.state = S_NUM_INT;
			end
			cst_pkg::CH_QUOTE: begin
				r.tok_v     = 1'b0;
				r.state     = S_STRING;
				r.len       = '0;
				r.set_quote = 1'b1;
			end
			cst_pkg::CH_EQ: begin
				r.tok_v = 1'b0;
				r.state = S_EQ;
			end
			cst_pkg::CH_BANG: begin
				r.tok_v = 1'b0;
				r.state = S_BANG;
			end
			cst_pkg::CH_LT: begin
				r.tok_v = 1'b0;
				r.state = S_LT;
			end
			cst_pkg::CH_GT: begin
				r.tok_v = 1'b0;
				r.state = S_GT;
			end
			cst_pkg::CH_PLUS:  r.kind = cst_pkg::K_PLUS;
			cst_pkg::CH_MINUS: r.kind = cst_pkg::K_MINUS;
			cst_pkg::CH_STAR:  r.kind = cst_pkg::K_STAR;
			cst_pkg::CH_PCT:   r.kind = cst_pkg::K_MOD;
			cst_pkg::CH_SEMI:  r.kind = cst_pkg::K_SEMI;
			cst_pkg::CH_LPA:   r.kind = cst_pkg::K_LPA;
			cst_pkg::CH_RPA:   r.kind = cst_pkg::K_RPA;
			cst_pkg::CH_LSB:   r.kind = cst_pkg::K_LSB;
			cst_pkg::CH_RSB:   r.kind = cst_pkg::K_RSB;
			cst_pkg::CH_LCB:   r.kind = cst_pkg::K_BEGIN;
			cst_pkg::CH_RCB:   r.kind = cst_pkg::K_END;
			cst_pkg::CH_COMMA: r.kind = cst_pkg::K_COMMA;
			default:           r.err  = cst_pkg::E_UNKNOWN;
		endcase
		return r;
	endfunction

	// Build a token with length saturation and the reported line width
	function automatic cst_pkg::token_t make_tok(
		input logic [cst_pkg::KIND_BITS-1:0] kind,
		input logic [cst_pkg::LEN_BITS-1:0]  len,
		input logic [LINE_BITS-1:0]          line,
		input logic [cst_pkg::ERR_BITS-1:0]  err
	);
		cst_pkg::token_t t;
		t.kind      = kind;
		t.saturated = len[cst_pkg::LEN_BITS-1];
		t.length    = len[cst_pkg::LEN_BITS-1] ? {cst_pkg::TLEN_BITS{1'b1}}
			: len[cst_pkg::TLEN_BITS-1:0];
		t.line      = cst_pkg::TLINE_BITS'(line);
		t.err       = err;
		t.last      = 1'b0;
		return t;
	endfunction

	// Character classes and the saturating lexeme count
	assign is_alpha = (in_byte >= 8'h61 && in_byte <= 8'h7a) ||
		(in_byte >= 8'h41 && in_byte <= 8'h5a);
	assign is_digit = in_byte >= 8'h30 && in_byte <= 8'h39;
	assign len_inc  = (len_q == LEN_MAX) ? len_q : len_q + cst_pkg::LEN_BITS'(1);
	assign sb       = start_byte(in_byte);

	// Next state and the tokens this transfer completes
	always_comb begin
		nxt_state = state_q;
		nxt_len   = len_q;
		nxt_sline = sline_q;
		nxt_quote = quote_q;
		nxt_line  = line_q;
		bump      = 1'b0;
		use_start = 1'b0;
		pre_v     = 1'b0;
		pre_tok   = make_tok(cst_pkg::K_DIV, cst_pkg::LEN_BITS'(1), sline_q,
			cst_pkg::E_NONE);
		sec_v     = 1'b0;
		sec_tok   = make_tok(sb.kind, cst_pkg::LEN_BITS'(1), line_q, sb.err);
		if (is_end) begin
			pre_v = 1'b1;
			unique case (state_q)
				S_SLASH: ;
				S_BLOCK, S_BLOCK_STAR, S_STRING:
					pre_tok = make_tok(cst_pkg::K_ERR, '0, sline_q, cst_pkg::E_UNTERM);
				S_IDENT:
					pre_tok = make_tok(cst_pkg::K_IDENT, len_q, sline_q, cst_pkg::E_NONE);
				S_NUM_INT, S_NUM_FRAC:
					pre_tok = make_tok(cst_pkg::K_NUM, len_q, sline_q, cst_pkg::E_NONE);
				S_EQ:
					pre_tok = make_tok(cst_pkg::K_ASSIGN, cst_pkg::LEN_BITS'(1),
						sline_q, cst_pkg::E_NONE);
				S_BANG:
					pre_tok = make_tok(cst_pkg::K_ERR, cst_pkg::LEN_BITS'(1),
						sline_q, cst_pkg::E_BANG);
				S_LT:
					pre_tok = make_tok(cst_pkg::K_LT, cst_pkg::LEN_BITS'(1),
						sline_q, cst_pkg::E_NONE);
				S_GT:
					pre_tok = make_tok(cst_pkg::K_GT, cst_pkg::LEN_BITS'(1),
						sline_q, cst_pkg::E_NONE);
				default: pre_v = 1'b0;
			endcase
			// Close with end-of-input and return to the reset state
			sec_v     = 1'b1;
			sec_tok   = make_tok(cst_pkg::K_EOF, '0, line_q, cst_pkg::E_NONE);
			nxt_state = S_START;
			nxt_len   = '0;
			nxt_sline = LINE_ONE;
			nxt_quote = '0;
			nxt_line  = LINE_ONE;
		end else begin
			unique case (state_q)
				S_SLASH: begin
					if (in_byte == cst_pkg::CH_SLASH) nxt_state = S_LINECOM;
					else if (in_byte == cst_pkg::CH_STAR) nxt_state = S_BLOCK;
					else begin
						pre_v     = 1'b1;
						use_start = 1'b1;
					end
				end
				S_LINECOM: begin
					if (in_byte == cst_pkg::CH_NL) begin
						bump      = 1'b1;
						nxt_state = S_START;
					end
				end
				S_BLOCK, S_BLOCK_STAR: begin
					if (state_q == S_BLOCK_STAR && in_byte == cst_pkg::CH_SLASH)
						nxt_state = S_START;
					else if (in_byte == cst_pkg::CH_STAR) nxt_state = S_BLOCK_STAR;
					else begin
						bump      = in_byte == cst_pkg::CH_NL;
						nxt_state = S_BLOCK;
					end
				end
				S_IDENT: begin
					if (is_alpha || is_digit || in_byte == cst_pkg::CH_UNDER)
						nxt_len = len_inc;
					else begin
						pre_v     = 1'b1;
						pre_tok   = make_tok(cst_pkg::K_IDENT, len_q, sline_q,
							cst_pkg::E_NONE);
						use_start = 1'b1;
					end
				end
				S_NUM_INT, S_NUM_FRAC: begin
					if (is_digit) nxt_len = len_inc;
					else if (state_q == S_NUM_INT && in_byte == cst_pkg::CH_DOT) begin
						nxt_len   = len_inc;
						nxt_state = S_NUM_FRAC;
					end else begin
						pre_v     = 1'b1;
						pre_tok   = make_tok(cst_pkg::K_NUM, len_q, sline_q,
							cst_pkg::E_NONE);
						use_start = 1'b1;
					end
				end
				S_STRING: begin
					if (in_byte == quote_q) begin
						pre_v     = 1'b1;
						pre_tok   = make_tok(cst_pkg::K_STR, len_q, sline_q,
							cst_pkg::E_NONE);
						nxt_state = S_START;
					end else nxt_len = len_inc;
				end
				S_EQ, S_BANG, S_LT, S_GT: begin
					pre_v = 1'b1;
					if (in_byte == cst_pkg::CH_EQ) begin
						nxt_state = S_START;
						pre_tok   = make_tok(
							(state_q == S_EQ) ? cst_pkg::K_EQ :
							(state_q == S_BANG) ? cst_pkg::K_NEQ :
							(state_q == S_LT) ? cst_pkg::K_LEQ : cst_pkg::K_GEQ,
							cst_pkg::LEN_BITS'(2), sline_q, cst_pkg::E_NONE);
					end else begin
						use_start = 1'b1;
						pre_tok   = make_tok(
							(state_q == S_EQ) ? cst_pkg::K_ASSIGN :
							(state_q == S_BANG) ? cst_pkg::K_ERR :
							(state_q == S_LT) ? cst_pkg::K_LT : cst_pkg::K_GT,
							cst_pkg::LEN_BITS'(1), sline_q,
							(state_q == S_BANG) ? cst_pkg::E_BANG : cst_pkg::E_NONE);
					end
				end
				default: use_start = 1'b1;
			endcase
			// Restart lexing on this byte
			if (use_start) begin
				nxt_state = sb.state;
				nxt_len   = sb.len;
				nxt_sline = line_q;
				if (sb.set_quote) nxt_quote = in_byte;
				bump      = sb.bump;
				sec_v     = sb.tok_v;
			end
			if (bump && line_q != LINE_MAX) nxt_line = line_q + LINE_ONE;
		end
	end

	// Pack the tokens in order and mark the final one
	always_comb begin
		emit = '0;
		if (pre_v) begin
			emit.tok0      = pre_tok;
			emit.tok0.last = !sec_v;
			emit.tok1      = sec_tok;
			emit.tok1.last = 1'b1;
			emit.count     = sec_v ? 2'd2 : 2'd1;
		end else begin
			emit.tok0      = sec_tok;
			emit.tok0.last = 1'b1;
			emit.tok1      = sec_tok;
			emit.count     = sec_v ? 2'd1 : 2'd0;
		end
		if (!step) emit.count = 2'd0;
	end

	// Advance lexer state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
			line_q  <= LINE_ONE;
			len_q   <= '0;
			sline_q <= LINE_ONE;
			quote_q <= '0;
		end else if (step) begin
			state_q <= nxt_state;
			line_q  <= nxt_line;
			len_q   <= nxt_len;
			sline_q <= nxt_sline;
			quote_q <= nxt_quote;
		end
	end

endmodule

FILE: hdl/cst_token_fifo.sv
// Four-entry result queue: takes up to two tokens per cycle, gives one if nonempty and out_ready.
// Depends on cst_pkg for the token and emit types.
`timescale 1ns / 1ps

module cst_token_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  cst_pkg::emit_t  push,
	output logic            has_room,
	output logic            out_valid,
	input  logic            out_ready,
	output cst_pkg::token_t out_tok
);

	cst_pkg::token_t                 mem_q [cst_pkg::QDEPTH];
	logic [cst_pkg::QPTR_BITS-1:0]   wr_q;
	logic [cst_pkg::QPTR_BITS-1:0]   rd_q;
	logic [cst_pkg::QCNT_BITS-1:0]   cnt_q;
	logic                            pop;
	logic [cst_pkg::QPTR_BITS-1:0]   wr_next;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign has_room  = cnt_q <= cst_pkg::QCNT_BITS'(cst_pkg::QDEPTH - 2);
	assign out_tok   = mem_q[rd_q];
	assign wr_next   = wr_q + cst_pkg::QPTR_BITS'(1);

	// Store incoming tokens
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_q] <= push.tok0;
		if (push.count == 2'd2) mem_q[wr_next] <= push.tok1;
	end

	// Track pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + cst_pkg::QPTR_BITS'(push.count);
			rd_q  <= rd_q + cst_pkg::QPTR_BITS'(pop);
			cnt_q <= cnt_q + cst_pkg::QCNT_BITS'(push.count) - cst_pkg::QCNT_BITS'(pop);
		end
	end

endmodule
